// ===== rtl/rc4_pkg.sv =====
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W          = 8;
    localparam int PERM_DEPTH      = 256;
    localparam int KEY_STORE_DEPTH = 256;
    localparam int KEY_LEN_W       = 9;
    localparam int CMD_W           = 2;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_FULL  = 9'd256;
    localparam logic [BYTE_W-1:0]    BYTE_LAST     = 8'd255;

    // command codes carried on the input tuser
    localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CRYPT    = 2'd2;

    // one write port and one read port of the permutation memory
    typedef struct packed {
        logic              we;
        logic [BYTE_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic [BYTE_W-1:0] raddr;
    } t_perm_req;

endpackage

// ===== rtl/rc4_stream_cipher_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Handshake                      Contents (lowest bit first)
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: key_index[7:0], in_byte[15:8];
//                                               tuser: command; tlast: end_of_message
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: out_byte[7:0]; tlast: last_byte
// cfg       in   i_cfg_wr_en                    i_cfg_wr_data: key_len
//
// Load key byte: stored on accept; the block stays ready. Crypt: RD_I, RD_J, WR_I, WR_J
// and RD_T serve in turn the five reads and writes on one permutation memory port pair,
// then OUT loads the result register. Schedule key: identity fill, then 256 key steps.
// After reset the identity fill runs once; s_axis_tready stays low.
// A finished result waits in the output register; the next item is taken meanwhile,
// and only a second crypt result holds the sequencer until the register frees.

module rc4_stream_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [8:0]  i_cfg_wr_data,   // key_len
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // key_index[7:0], in_byte[15:8]
    input  logic [1:0]  s_axis_tuser,    // command
    input  logic        s_axis_tlast,    // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // out_byte
    output logic        m_axis_tlast     // last_byte
);

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CR_RD_I,
        ST_CR_RD_J,
        ST_CR_WR_I,
        ST_CR_WR_J,
        ST_CR_RD_T,
        ST_CR_OUT,
        ST_KS_RD_N,
        ST_KS_RD_J,
        ST_KS_WR_N,
        ST_KS_WR_J
    } t_state;

    t_state                       r_state;
    logic                         r_sched;
    logic [rc4_pkg::BYTE_W-1:0]   r_n;
    logic [rc4_pkg::BYTE_W-1:0]   r_i;
    logic [rc4_pkg::BYTE_W-1:0]   r_j;
    logic [rc4_pkg::BYTE_W-1:0]   r_si;
    logic [rc4_pkg::BYTE_W-1:0]   r_sj;
    logic [rc4_pkg::BYTE_W-1:0]   r_t;
    logic [rc4_pkg::BYTE_W-1:0]   r_kpos;
    logic [rc4_pkg::BYTE_W-1:0]   r_data;
    logic                         r_eom;
    logic [rc4_pkg::KEY_LEN_W-1:0] r_key_len;
    logic                         r_out_valid;
    logic [rc4_pkg::BYTE_W-1:0]   r_out_data;
    logic                         r_out_last;

    logic [rc4_pkg::BYTE_W-1:0]   r_key_mem [rc4_pkg::KEY_STORE_DEPTH];
    logic [rc4_pkg::BYTE_W-1:0]   r_key_rdata;

    rc4_pkg::t_perm_req           w_req;
    logic [rc4_pkg::BYTE_W-1:0]   w_rdata;

    logic                         w_in_acc;
    logic                         w_out_free;
    logic [rc4_pkg::BYTE_W-1:0]   w_op_a;
    logic [rc4_pkg::BYTE_W-1:0]   w_op_b;
    logic [rc4_pkg::BYTE_W-1:0]   w_op_c;
    logic [rc4_pkg::BYTE_W-1:0]   w_sum;
    logic [rc4_pkg::KEY_LEN_W-1:0] w_eff_len;
    logic [rc4_pkg::KEY_LEN_W-1:0] w_kpos_inc;
    logic [rc4_pkg::BYTE_W-1:0]   n_kpos;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // zero length means a full 256-byte key
    assign w_eff_len  = (r_key_len == '0) ? rc4_pkg::KEY_LEN_FULL : r_key_len;
    assign w_kpos_inc = {1'b0, r_kpos} + 9'd1;
    assign n_kpos     = (w_kpos_inc == w_eff_len) ? '0 : w_kpos_inc[rc4_pkg::BYTE_W-1:0];

    // shared 8-bit adder: j update in both loops, keystream index in crypt
    always_comb begin
        w_op_a = r_j;
        w_op_b = w_rdata;
        w_op_c = '0;
        if (r_state == ST_CR_WR_J) begin
            w_op_a = r_si;
            w_op_b = r_sj;
        end else if (r_state == ST_KS_RD_J) begin
            w_op_c = r_key_rdata;
        end
    end
    assign w_sum = w_op_a + w_op_b + w_op_c;

    // permutation memory port control
    always_comb begin
        w_req.we    = 1'b0;
        w_req.waddr = r_n;
        w_req.wdata = r_n;
        w_req.raddr = r_i;
        unique case (r_state)
            ST_INIT: begin
                w_req.we = 1'b1;
            end
            ST_CR_RD_J: begin
                w_req.raddr = w_sum;
            end
            ST_CR_WR_I: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_i;
                w_req.wdata = w_rdata;
            end
            ST_CR_WR_J: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_si;
            end
            ST_CR_RD_T, ST_CR_OUT: begin
                w_req.raddr = r_t;
            end
            ST_KS_RD_N: begin
                w_req.raddr = r_n;
            end
            ST_KS_RD_J: begin
                w_req.raddr = w_sum;
            end
            ST_KS_WR_N: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_n;
                w_req.wdata = w_rdata;
            end
            ST_KS_WR_J: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_j;
                w_req.wdata = r_si;
            end
            default: begin
                w_req.we = 1'b0;
            end
        endcase
    end

    rc4_perm_mem u_perm (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // key store
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (s_axis_tuser == rc4_pkg::CMD_LOAD)) begin
            r_key_mem[s_axis_tdata[7:0]] <= s_axis_tdata[15:8];
        end
        r_key_rdata <= r_key_mem[r_kpos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sched     <= 1'b0;
            r_n         <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_kpos      <= '0;
            r_key_len   <= rc4_pkg::KEY_LEN_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_key_len <= i_cfg_wr_data;
            end
            // drop the sent item unless the last crypt step refills the register
            if (r_out_valid && m_axis_tready && (r_state != ST_CR_OUT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_INIT: begin
                    if (r_n == rc4_pkg::BYTE_LAST) begin
                        r_n     <= '0;
                        r_kpos  <= '0;
                        r_sched <= 1'b0;
                        r_state <= r_sched ? ST_KS_RD_N : ST_IDLE;
                    end else begin
                        r_n <= r_n + 8'd1;
                    end
                end
                ST_IDLE: begin
                    if (w_in_acc) begin
                        unique case (s_axis_tuser)
                            rc4_pkg::CMD_SCHEDULE: begin
                                r_sched <= 1'b1;
                                r_n     <= '0;
                                r_i     <= '0;
                                r_j     <= '0;
                                r_state <= ST_INIT;
                            end
                            rc4_pkg::CMD_CRYPT: begin
                                r_data  <= s_axis_tdata[15:8];
                                r_eom   <= s_axis_tlast;
                                r_i     <= r_i + 8'd1;
                                r_state <= ST_CR_RD_I;
                            end
                            default: begin
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_CR_RD_I: begin
                    r_state <= ST_CR_RD_J;
                end
                ST_CR_RD_J: begin
                    r_si    <= w_rdata;
                    r_j     <= w_sum;
                    r_state <= ST_CR_WR_I;
                end
                ST_CR_WR_I: begin
                    r_sj    <= w_rdata;
                    r_state <= ST_CR_WR_J;
                end
                ST_CR_WR_J: begin
                    r_t     <= w_sum;
                    r_state <= ST_CR_RD_T;
                end
                ST_CR_RD_T: begin
                    r_state <= ST_CR_OUT;
                end
                ST_CR_OUT: begin
                    // hold until the output register frees
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_data ^ w_rdata;
                        r_out_last  <= r_eom;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_KS_RD_N: begin
                    r_state <= ST_KS_RD_J;
                end
                ST_KS_RD_J: begin
                    r_si    <= w_rdata;
                    r_j     <= w_sum;
                    r_state <= ST_KS_WR_N;
                end
                ST_KS_WR_N: begin
                    r_state <= ST_KS_WR_J;
                end
                ST_KS_WR_J: begin
                    r_kpos <= n_kpos;
                    r_n    <= r_n + 8'd1;
                    if (r_n == rc4_pkg::BYTE_LAST) begin
                        r_j     <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_KS_RD_N;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // a crypt item keeps the block busy
    a_crypt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (s_axis_tuser == rc4_pkg::CMD_CRYPT)) |=> !s_axis_tready)
        else $error("block ready right after a crypt item");

    // a new result comes only from the last crypt step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_CR_OUT))
        else $error("result raised outside the crypt sequence");

    // key read position stays inside the key length
    a_kpos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_KS_RD_N) |-> ({1'b0, r_kpos} < w_eff_len))
        else $error("key position beyond key length");

    // the result register is never overwritten while still waiting
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CR_OUT && r_out_valid && !m_axis_tready) |=> (r_state == ST_CR_OUT))
        else $error("crypt step left while the output was stalled");
`endif

endmodule

// ===== rtl/rc4_perm_mem.sv =====
`timescale 1ns / 1ps

module rc4_perm_mem (
    input  logic                     i_clk,
    input  rc4_pkg::t_perm_req       i_req,
    output logic [rc4_pkg::BYTE_W-1:0] o_rdata
);

    logic [rc4_pkg::BYTE_W-1:0] r_mem [rc4_pkg::PERM_DEPTH];
    logic [rc4_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== tb/rc4_stream_cipher_core_tb.sv =====
`timescale 1ns / 1ps

module rc4_stream_cipher_core_tb;

    localparam logic [rc4_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ITEM_TARGET   = 1550;
    localparam int CALM_ITEMS    = 150;
    localparam int REKEY_CYCLES  = 1400;  // identity fill + 256 key steps, with margin
    localparam int DRAIN_CYCLES  = 50;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [rc4_pkg::BYTE_W-1:0] out_byte;
        logic                       last_byte;
    } t_ct_byte;

    class t_cipher_scoreboard;
        logic [rc4_pkg::BYTE_W-1:0]    perm [rc4_pkg::PERM_DEPTH];
        logic [rc4_pkg::BYTE_W-1:0]    key_bytes [rc4_pkg::KEY_STORE_DEPTH];
        logic [rc4_pkg::BYTE_W-1:0]    idx_i;
        logic [rc4_pkg::BYTE_W-1:0]    idx_j;
        logic [rc4_pkg::KEY_LEN_W-1:0] key_len;
        t_ct_byte                      ciphertext_q [$];
        int                            mismatches;
        int                            results_seen;

        function new();
            foreach (perm[n]) perm[n] = 8'(n);
            foreach (key_bytes[n]) key_bytes[n] = '0;
            idx_i        = '0;
            idx_j        = '0;
            key_len      = rc4_pkg::KEY_LEN_RESET;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_key_len(logic [rc4_pkg::KEY_LEN_W-1:0] value);
            key_len = value;
        endfunction

        // identity fill, then the 256-step key schedule
        function void rekey();
            int                         len;
            int                         n;
            logic [rc4_pkg::BYTE_W-1:0] jj;
            logic [rc4_pkg::BYTE_W-1:0] t;
            len = (key_len == 0) ? 256 : int'(key_len);
            foreach (perm[k]) perm[k] = 8'(k);
            idx_i = '0;
            idx_j = '0;
            jj    = '0;
            for (n = 0; n < rc4_pkg::PERM_DEPTH; n++) begin
                jj = jj + perm[n] + key_bytes[(n % len) % rc4_pkg::KEY_STORE_DEPTH];
                t        = perm[n];
                perm[n]  = perm[jj];
                perm[jj] = t;
            end
        endfunction

        function void accept_item(logic [rc4_pkg::CMD_W-1:0] cmd,
                                  logic [rc4_pkg::BYTE_W-1:0] kidx,
                                  logic [rc4_pkg::BYTE_W-1:0] data_byte, logic eom);
            logic [rc4_pkg::BYTE_W-1:0] ni;
            logic [rc4_pkg::BYTE_W-1:0] nj;
            logic [rc4_pkg::BYTE_W-1:0] t;
            t_ct_byte                   ct;
            unique case (cmd)
                rc4_pkg::CMD_LOAD: begin
                    key_bytes[kidx] = data_byte;
                end
                rc4_pkg::CMD_SCHEDULE: begin
                    rekey();
                end
                rc4_pkg::CMD_CRYPT: begin
                    ni = idx_i + 8'd1;
                    nj = idx_j + perm[ni];
                    t        = perm[ni];
                    perm[ni] = perm[nj];
                    perm[nj] = t;
                    t = perm[ni] + perm[nj];
                    idx_i = ni;
                    idx_j = nj;
                    ct.out_byte  = data_byte ^ perm[t];
                    ct.last_byte = eom;
                    ciphertext_q.push_back(ct);
                end
                default: begin
                    // unused command: drop
                end
            endcase
        endfunction

        function void check_output(logic [rc4_pkg::BYTE_W-1:0] out_byte, logic last_byte);
            t_ct_byte want;
            results_seen++;
            if (ciphertext_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected output byte %02h last %0b", out_byte, last_byte);
                return;
            end
            want = ciphertext_q.pop_front();
            if (want.out_byte !== out_byte || want.last_byte !== last_byte) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("output %0d: expected %02h last %0b, got %02h last %0b",
                             results_seen, want.out_byte, want.last_byte, out_byte, last_byte);
            end
        endfunction

        function int pending();
            return ciphertext_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [8:0]  i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    t_cipher_scoreboard board;
    bit                 key_written [rc4_pkg::KEY_STORE_DEPTH];
    bit                 calm;
    int                 items_sent;
    int                 cycles;

    rc4_stream_cipher_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one item and hold it until taken; called right after a rising edge
    task automatic push_item(input logic [rc4_pkg::CMD_W-1:0] cmd, input logic [7:0] kidx,
                             input logic [7:0] data_byte, input logic eom);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {data_byte, kidx};
        s_axis_tuser  <= cmd;
        s_axis_tlast  <= eom;
        do @(posedge i_clk); while (!s_axis_tready);
        board.accept_item(cmd, kidx, data_byte, eom);
        if (cmd == rc4_pkg::CMD_LOAD)
            key_written[kidx] = 1'b1;
        items_sent++;
    endtask

    // drain everything, let a key schedule finish, then write the key length register
    task automatic write_key_len(input logic [8:0] value);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (REKEY_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        board.set_key_len(value);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // new key length: load the key bytes it needs, schedule, then mostly crypt
    task automatic run_phase(input logic [8:0] len, input int mix_items);
        int eff;
        int pos;
        int pick;
        int n;
        write_key_len(len);
        eff = (len == 0 || len > 256) ? 256 : int'(len);
        for (pos = 0; pos < eff; pos++) begin
            if (!key_written[pos] || $urandom_range(0, 3) == 0)
                push_item(rc4_pkg::CMD_LOAD, pos[7:0], 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)));
        end
        push_item(rc4_pkg::CMD_SCHEDULE, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        for (n = 0; n < mix_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                push_item(rc4_pkg::CMD_CRYPT, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            else if (pick < 85)
                push_item(rc4_pkg::CMD_SCHEDULE, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else if (pick < 92)
                push_item(rc4_pkg::CMD_LOAD, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            else
                push_item(CMD_UNUSED, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end
    endtask

    // output side: random stalls, one long hold-off to back the block up
    initial begin : sink
        int  hold;
        bit  long_done;
        hold      = 0;
        long_done = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                board.check_output(m_axis_tdata, m_axis_tlast);
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else if (!long_done && board.results_seen >= 40) begin
                long_done = 1'b1;
                hold      = LONG_HOLD;
                m_axis_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                hold = $urandom_range(1, 7) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [8:0] key_lens [8];
        int         p;
        int         k;
        key_lens = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd255, 9'd64, 9'd257};
        board      = new();
        calm       = 1'b0;
        items_sent = 0;
        foreach (key_written[n]) key_written[n] = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= rc4_pkg::CMD_LOAD;
        s_axis_tlast  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: crypt on the reset permutation, unused command, key of 16, extremes
        push_item(rc4_pkg::CMD_CRYPT, 8'h00, 8'h00, 1'b0);
        push_item(CMD_UNUSED, 8'h00, 8'h00, 1'b0);
        push_item(rc4_pkg::CMD_LOAD, 8'd0, 8'h00, 1'b0);
        push_item(rc4_pkg::CMD_LOAD, 8'd1, 8'hFF, 1'b1);
        for (k = 2; k < 16; k++)
            push_item(rc4_pkg::CMD_LOAD, k[7:0], 8'($urandom_range(0, 255)), 1'b0);
        push_item(rc4_pkg::CMD_LOAD, rc4_pkg::BYTE_LAST, rc4_pkg::BYTE_LAST, 1'b0);
        push_item(rc4_pkg::CMD_SCHEDULE, 8'h00, 8'h00, 1'b0);
        push_item(rc4_pkg::CMD_CRYPT, rc4_pkg::BYTE_LAST, 8'hFF, 1'b1);
        push_item(rc4_pkg::CMD_CRYPT, 8'h00, 8'h00, 1'b0);
        push_item(rc4_pkg::CMD_CRYPT, 8'h5A, 8'hA5, 1'b1);
        push_item(CMD_UNUSED, rc4_pkg::BYTE_LAST, 8'hFF, 1'b1);

        p = 0;
        while (items_sent < ITEM_TARGET - CALM_ITEMS) begin
            run_phase(p < 8 ? key_lens[p] : 9'($urandom_range(0, 511)),
                      $urandom_range(60, 140));
            p++;
        end
        calm = 1'b1;
        run_phase(9'($urandom_range(1, 32)), CALM_ITEMS);

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.mismatches++;
            $display("%0d output bytes never arrived", board.pending());
        end
        if (board.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
